// File: design/wind_sentence_parser_defines.svh
// Assertion macros shared by the wind sentence parser modules.
`ifndef WIND_SENTENCE_PARSER_DEFINES_SVH
`define WIND_SENTENCE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/wsp_pkg.sv
// Shared types and constants of the wind sentence parser.
package wsp_pkg;

    localparam int unsigned MAX_MESSAGE_BYTES = 64;

    localparam int unsigned MSG_LEN_W    = 7;
    localparam int unsigned SPEED_W      = 14;
    localparam int unsigned HEADING_W    = 9;
    localparam int unsigned STATE_W      = 4;
    localparam int unsigned TEMP_W       = 15;

    localparam logic [MSG_LEN_W-1:0] MSG_LEN_RESET = 7'd35;

    // Sentence characters
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_W      = 8'h57;
    localparam logic [7:0] CHAR_I      = 8'h49;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Result queue between the parser and the output channel
    localparam int unsigned RES_DEPTH = 2;
    localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef logic [MSG_LEN_W-1:0] t_msg_len;

    typedef struct packed {
        logic [SPEED_W-1:0]          wind_speed_tenths;
        logic signed [HEADING_W-1:0] heading_deg;
        logic [STATE_W-1:0]          sensor_state;
        logic signed [TEMP_W-1:0]    temperature_tenths;
        logic                        format_error;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_push;

endpackage

// File: design/wsp_ifs.sv
// Channel interfaces of the wind sentence parser: byte input, result output, config.
interface wsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wsp_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [wsp_pkg::SPEED_W-1:0]          wind_speed_tenths;
    logic signed [wsp_pkg::HEADING_W-1:0] heading_deg;
    logic [wsp_pkg::STATE_W-1:0]          sensor_state;
    logic signed [wsp_pkg::TEMP_W-1:0]    temperature_tenths;
    logic                                 format_error;

    modport source (output valid, output wind_speed_tenths, output heading_deg,
                    output sensor_state, output temperature_tenths,
                    output format_error, input ready);
    modport sink   (input valid, input wind_speed_tenths, input heading_deg,
                    input sensor_state, input temperature_tenths,
                    input format_error, output ready);
endinterface

interface wsp_cfg_if;
    logic                   valid;
    logic                   ready;
    wsp_pkg::t_msg_len      message_length;

    modport source (output valid, output message_length, input ready);
    modport sink   (input valid, input message_length, output ready);
endinterface

// File: design/wind_sentence_parser.sv
// Top level of the wind sentence parser.
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    data_byte[7:0], last_byte
//  o_out     out  valid/ready    wind_speed_tenths, heading_deg, sensor_state,
//                                temperature_tenths, format_error
//  i_cfg     in   valid/ready    message_length[6:0] (ready always high)
//
// One byte is taken per cycle while the result queue has space; a result is
// registered into the result queue when its last byte is accepted. The
// per-byte update is a single pass of counters and a multiply-by-ten step
// between the sentence registers and the result queue. A two-entry result
// queue lets bytes keep flowing while a result waits; i_in.ready drops only
// while both entries are occupied. Reset is synchronous and active low, and
// message length returns to 35.
module wind_sentence_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wsp_in_if.sink    i_in,
    wsp_out_if.source o_out,
    wsp_cfg_if.sink   i_cfg
);

    wsp_pkg::t_msg_len r_message_length;
    wsp_pkg::t_push    push;
    wsp_pkg::t_result  result;
    logic              queue_space;
    logic              in_accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = queue_space;
    assign in_accept   = i_in.valid && queue_space;

    // Latch the configured sentence length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_message_length <= wsp_pkg::MSG_LEN_RESET;
        end else if (i_cfg.valid) begin
            r_message_length <= i_cfg.message_length;
        end
    end

    wsp_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_data_byte      (i_in.data_byte),
        .i_last_byte      (i_in.last_byte),
        .i_message_length (r_message_length),
        .o_push           (push)
    );

    wsp_res_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (queue_space),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (result)
    );

    // Spread the result onto the output channel
    assign o_out.wind_speed_tenths  = result.wind_speed_tenths;
    assign o_out.heading_deg        = result.heading_deg;
    assign o_out.sensor_state       = result.sensor_state;
    assign o_out.temperature_tenths = result.temperature_tenths;
    assign o_out.format_error       = result.format_error;

endmodule

// File: design/wsp_parse.sv
// Per-byte sentence state update and result formation on the last byte.
`include "wind_sentence_parser_defines.svh"

module wsp_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  wsp_pkg::t_msg_len  i_message_length,
    output wsp_pkg::t_push     o_push
);

    localparam logic [2:0] FIELD_SPEED   = 3'd1;
    localparam logic [2:0] FIELD_HEADING = 3'd2;
    localparam logic [2:0] FIELD_STATE   = 3'd3;
    localparam logic [2:0] FIELD_TEMP    = 3'd4;
    localparam logic [2:0] COMMA_MAX     = 3'd7;

    localparam logic [5:0] BSC_MAX       = 6'd63;
    localparam logic [5:0] TEMP_TAIL     = 6'd6;
    localparam logic [6:0] BYTE_CNT_MAX  = 7'd127;
    localparam logic [6:0] HEADER_BYTES  = 7'd3;
    localparam logic [6:0] MSG_LEN_MAX   = 7'(wsp_pkg::MAX_MESSAGE_BYTES);

    localparam logic [9:0]  HDG_CLAMP    = 10'd360;
    localparam logic [9:0]  HDG_WRAP     = 10'd180;
    localparam logic signed [10:0] HDG_TURN = 11'sd360;

    // Last digit offset of each field after its comma
    function automatic logic [5:0] field_end(input logic [2:0] field);
        logic [5:0] off;
        unique case (field)
            FIELD_SPEED:   off = 6'd9;
            FIELD_HEADING: off = 6'd3;
            FIELD_STATE:   off = 6'd1;
            FIELD_TEMP:    off = 6'd6;
            default:       off = 6'd0;
        endcase
        return off;
    endfunction

    logic [6:0]  r_byte_count, n_byte_count, u_byte_count;
    logic [2:0]  r_comma_count, n_comma_count, u_comma_count;
    logic [5:0]  r_bsc, n_bsc, u_bsc;
    logic        r_header_ok, n_header_ok, u_header_ok;
    logic [13:0] r_speed, n_speed, u_speed;
    logic [9:0]  r_heading, n_heading, u_heading;
    logic [3:0]  r_state_digit, n_state_digit, u_state_digit;
    logic [13:0] r_temp, n_temp, u_temp;
    logic        r_temp_neg, n_temp_neg, u_temp_neg;
    logic        r_error, n_error, u_error;

    logic        is_digit;
    logic [3:0]  digit;
    logic [5:0]  pos;
    logic        matched;
    logic        fmt_err;
    logic [9:0]  hdg_clamped;
    logic signed [10:0] hdg_wrapped;
    logic signed [14:0] temp_mag;
    logic signed [14:0] temp_val;

    // Fold one byte into the sentence state
    always_comb begin
        is_digit = (i_data_byte >= wsp_pkg::CHAR_ZERO) && (i_data_byte <= wsp_pkg::CHAR_NINE);
        digit    = is_digit ? i_data_byte[3:0] : 4'd0;
        pos      = (r_bsc < BSC_MAX) ? 6'(r_bsc + 6'd1) : r_bsc;

        u_byte_count  = (r_byte_count < BYTE_CNT_MAX) ? 7'(r_byte_count + 7'd1)
                                                      : r_byte_count;
        u_comma_count = r_comma_count;
        u_bsc         = r_bsc;
        u_header_ok   = r_header_ok;
        u_speed       = r_speed;
        u_heading     = r_heading;
        u_state_digit = r_state_digit;
        u_temp        = r_temp;
        u_temp_neg    = r_temp_neg;
        u_error       = r_error;

        // Check the three header bytes
        if ((r_byte_count == 7'd0) && (i_data_byte != wsp_pkg::CHAR_DOLLAR))
            u_header_ok = 1'b0;
        if ((r_byte_count == 7'd1) && (i_data_byte != wsp_pkg::CHAR_W))
            u_header_ok = 1'b0;
        if ((r_byte_count == 7'd2) && (i_data_byte != wsp_pkg::CHAR_I))
            u_header_ok = 1'b0;

        if (i_data_byte == wsp_pkg::CHAR_COMMA) begin
            // Flag a field cut short by an early comma
            if ((r_comma_count >= FIELD_SPEED) && (r_comma_count <= FIELD_TEMP) &&
                (r_bsc < field_end(r_comma_count))) begin
                u_error = 1'b1;
            end
            if (r_comma_count < COMMA_MAX) begin
                u_comma_count = 3'(r_comma_count + 3'd1);
            end
            u_bsc = 6'd0;
        end else begin
            u_bsc = pos;
            case (r_comma_count)
                FIELD_SPEED: begin
                    if (pos inside {6'd5, 6'd6, 6'd7, 6'd9}) begin
                        u_speed = 14'((r_speed << 3) + (r_speed << 1) + 14'(digit));
                        if (!is_digit) u_error = 1'b1;
                    end
                end
                FIELD_HEADING: begin
                    if ((pos >= 6'd1) && (pos <= 6'd3)) begin
                        u_heading = 10'((r_heading << 3) + (r_heading << 1) + 10'(digit));
                        if (!is_digit) u_error = 1'b1;
                    end
                end
                FIELD_STATE: begin
                    if (pos == 6'd1) begin
                        u_state_digit = digit;
                        if (!is_digit) u_error = 1'b1;
                    end
                end
                FIELD_TEMP: begin
                    if (pos == 6'd1) begin
                        u_temp_neg = (i_data_byte == wsp_pkg::CHAR_MINUS);
                    end else if (pos inside {6'd2, 6'd3, 6'd4, 6'd6}) begin
                        u_temp = 14'((r_temp << 3) + (r_temp << 1) + 14'(digit));
                        if (!is_digit) u_error = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Judge the finished sentence and shape its fields
    always_comb begin
        matched = u_header_ok && (u_byte_count >= HEADER_BYTES) &&
                  (i_message_length >= 7'd1) &&
                  (i_message_length <= MSG_LEN_MAX) &&
                  (u_byte_count == i_message_length);
        fmt_err = u_error || (u_comma_count < FIELD_TEMP) ||
                  ((u_comma_count == FIELD_TEMP) && (u_bsc < TEMP_TAIL));

        hdg_clamped = (u_heading > HDG_CLAMP) ? HDG_CLAMP : u_heading;
        hdg_wrapped = (hdg_clamped >= HDG_WRAP)
                    ? $signed({1'b0, hdg_clamped}) - HDG_TURN
                    : $signed({1'b0, hdg_clamped});
        temp_mag    = $signed({1'b0, u_temp});
        temp_val    = u_temp_neg ? -temp_mag : temp_mag;

        o_push.valid = i_accept && i_last_byte && matched;
        if (fmt_err) begin
            o_push.result.wind_speed_tenths  = '0;
            o_push.result.heading_deg        = '0;
            o_push.result.sensor_state       = '0;
            o_push.result.temperature_tenths = '0;
            o_push.result.format_error       = 1'b1;
        end else begin
            o_push.result.wind_speed_tenths  = u_speed;
            o_push.result.heading_deg        = hdg_wrapped[8:0];
            o_push.result.sensor_state       = u_state_digit;
            o_push.result.temperature_tenths = temp_val;
            o_push.result.format_error       = 1'b0;
        end
    end

    // Clear the sentence state after every last byte
    always_comb begin
        if (i_last_byte) begin
            n_byte_count  = '0;
            n_comma_count = '0;
            n_bsc         = '0;
            n_header_ok   = 1'b1;
            n_speed       = '0;
            n_heading     = '0;
            n_state_digit = '0;
            n_temp        = '0;
            n_temp_neg    = 1'b0;
            n_error       = 1'b0;
        end else begin
            n_byte_count  = u_byte_count;
            n_comma_count = u_comma_count;
            n_bsc         = u_bsc;
            n_header_ok   = u_header_ok;
            n_speed       = u_speed;
            n_heading     = u_heading;
            n_state_digit = u_state_digit;
            n_temp        = u_temp;
            n_temp_neg    = u_temp_neg;
            n_error       = u_error;
        end
    end

    // Advance the state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_comma_count <= '0;
            r_bsc         <= '0;
            r_header_ok   <= 1'b1;
            r_speed       <= '0;
            r_heading     <= '0;
            r_state_digit <= '0;
            r_temp        <= '0;
            r_temp_neg    <= 1'b0;
            r_error       <= 1'b0;
        end else if (i_accept) begin
            r_byte_count  <= n_byte_count;
            r_comma_count <= n_comma_count;
            r_bsc         <= n_bsc;
            r_header_ok   <= n_header_ok;
            r_speed       <= n_speed;
            r_heading     <= n_heading;
            r_state_digit <= n_state_digit;
            r_temp        <= n_temp;
            r_temp_neg    <= n_temp_neg;
            r_error       <= n_error;
        end
    end

    `WSP_ASSERT_NXT(a_clear_after_last, i_clk, i_rst_n, i_accept && i_last_byte,
        (r_byte_count == 7'd0) && (r_comma_count == 3'd0) && r_header_ok && !r_error,
        "sentence state not cleared after last byte")

    `WSP_ASSERT_IMP(a_push_needs_last, i_clk, i_rst_n, o_push.valid,
        i_accept && i_last_byte && (u_byte_count == i_message_length),
        "result pushed without a matching last byte")

    `WSP_ASSERT_IMP(a_error_zeroes, i_clk, i_rst_n,
        o_push.valid && o_push.result.format_error,
        (o_push.result.wind_speed_tenths == '0) && (o_push.result.heading_deg == '0) &&
        (o_push.result.sensor_state == '0) && (o_push.result.temperature_tenths == '0),
        "format error result carries nonzero fields")

endmodule

// File: design/wsp_res_queue.sv
// Two-entry result queue that decouples the parser from the output channel.
`include "wind_sentence_parser_defines.svh"

module wsp_res_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wsp_pkg::t_push   i_push,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_ready,
    output wsp_pkg::t_result o_result
);

    localparam logic [wsp_pkg::RES_CNT_W-1:0] CNT_FULL =
        wsp_pkg::RES_CNT_W'(wsp_pkg::RES_DEPTH);
    localparam logic [wsp_pkg::RES_PTR_W-1:0] PTR_LAST =
        wsp_pkg::RES_PTR_W'(wsp_pkg::RES_DEPTH - 1);

    wsp_pkg::t_result                r_mem [wsp_pkg::RES_DEPTH];
    logic [wsp_pkg::RES_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [wsp_pkg::RES_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [wsp_pkg::RES_CNT_W-1:0]   r_count, n_count;
    logic                            pop;

    function automatic logic [wsp_pkg::RES_PTR_W-1:0] RES_PTR_INC(
        input logic [wsp_pkg::RES_PTR_W-1:0] ptr);
        return wsp_pkg::RES_PTR_W'(ptr + 1'b1);
    endfunction

    // Drive the handshake and pointer updates
    always_comb begin
        o_space  = (r_count != CNT_FULL);
        o_valid  = (r_count != '0);
        pop      = o_valid && i_ready;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : RES_PTR_INC(r_wr_ptr);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : RES_PTR_INC(r_rd_ptr);
        end
        case ({i_push.valid, pop})
            2'b10:   n_count = wsp_pkg::RES_CNT_W'(r_count + 1'b1);
            2'b01:   n_count = wsp_pkg::RES_CNT_W'(r_count - 1'b1);
            default: n_count = r_count;
        endcase
    end

    assign o_result = r_mem[r_rd_ptr];

    // Hold results until taken
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `WSP_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push.valid, r_count != CNT_FULL,
        "result pushed into a full queue")

    `WSP_ASSERT_NXT(a_count_tracks, i_clk, i_rst_n, i_push.valid && !pop,
        r_count == wsp_pkg::RES_CNT_W'($past(r_count) + 1'b1),
        "queue count did not advance on push")

endmodule
